// ----- rtl/rgb_to_hsv_convert_defines.svh -----
// assertion macros used by the checker file of the rgb to hsv converter
// no dependencies; each macro expects clk and rst_n in the including scope
`ifndef RGB_TO_HSV_CONVERT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RHC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rhc_pkg.sv -----
// shared constants, pipeline types and divider step functions
// for the rgb to hsv converter; no dependencies
`default_nettype none

package rhc_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int HUE_BITS     = 16;
  localparam int SAT_BITS     = 16;

  // divider organization: quotient bits resolved per pipeline stage
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_BITS_MIN    = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;
  localparam int DIV_STAGES      = (DIV_BITS_MIN + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DIV_BITS        = DIV_STAGES * STEPS_PER_STAGE;

  // hue divisor is 6*d, which needs three more bits than a channel
  localparam int HDIV_W = CHANNEL_BITS + 3;
  localparam int SDIV_W = CHANNEL_BITS;
  // saturation dividend is full_scale*d
  localparam int SATN_W = CHANNEL_BITS + SAT_BITS;

  // pixel after the max/min classification stage
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [CHANNEL_BITS-1:0] hi;
    logic [CHANNEL_BITS-1:0] lo;
    logic                    red_max;
    logic                    green_max;
  } color_info_t;

  // state of both dividers as it travels down the pipeline
  typedef struct packed {
    logic [HDIV_W-1:0]       hue_rem;
    logic [HDIV_W-1:0]       hue_div;
    logic [DIV_BITS-1:0]     hue_quo;
    logic [SDIV_W-1:0]       sat_rem;
    logic [SDIV_W-1:0]       sat_div;
    logic [DIV_BITS-1:0]     sat_src;
    logic [DIV_BITS-1:0]     sat_quo;
    logic                    hue_zero;
    logic                    sat_zero;
    logic [CHANNEL_BITS-1:0] value;
  } div_state_t;

  typedef struct packed {
    logic              qbit;
    logic [HDIV_W-1:0] rem;
  } hue_step_t;

  typedef struct packed {
    logic              qbit;
    logic [SDIV_W-1:0] rem;
  } sat_step_t;

  // one restoring step of the hue division, dividend bits below are zero
  function automatic hue_step_t hue_div_step(input logic [HDIV_W-1:0] rem,
                                             input logic [HDIV_W-1:0] dvs);
    logic [HDIV_W:0] wide;
    logic [HDIV_W:0] diff;
    hue_step_t       res;
    wide = {rem, 1'b0};
    diff = wide - {1'b0, dvs};
    if (wide >= {1'b0, dvs}) begin
      res.qbit = 1'b1;
      res.rem  = diff[HDIV_W-1:0];
    end else begin
      res.qbit = 1'b0;
      res.rem  = wide[HDIV_W-1:0];
    end
    return res;
  endfunction

  // one restoring step of the saturation division, shifting in a dividend bit
  function automatic sat_step_t sat_div_step(input logic [SDIV_W-1:0] rem,
                                             input logic [SDIV_W-1:0] dvs,
                                             input logic              in_bit);
    logic [SDIV_W:0] wide;
    logic [SDIV_W:0] diff;
    sat_step_t       res;
    wide = {rem, in_bit};
    diff = wide - {1'b0, dvs};
    if (wide >= {1'b0, dvs}) begin
      res.qbit = 1'b1;
      res.rem  = diff[SDIV_W-1:0];
    end else begin
      res.qbit = 1'b0;
      res.rem  = wide[SDIV_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rhc_prep.sv -----
// front end of the converter: max/min classification and divider setup,
// two elastic register stages; depends on rhc_pkg
`default_nettype none

module rhc_prep (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              up_valid,
  output logic                             up_ready,
  input  wire  [rhc_pkg::CHANNEL_BITS-1:0] red,
  input  wire  [rhc_pkg::CHANNEL_BITS-1:0] green,
  input  wire  [rhc_pkg::CHANNEL_BITS-1:0] blue,
  output logic                             dn_valid,
  input  wire                              dn_ready,
  output rhc_pkg::div_state_t              dn_data
);
  import rhc_pkg::*;

  color_info_t info_nxt;
  color_info_t info_r;
  logic        s1_valid_r;
  logic        s1_ready;
  div_state_t  setup_nxt;
  div_state_t  setup_r;
  logic        s2_valid_r;
  logic        s2_ready;

  logic [CHANNEL_BITS-1:0] d;
  logic [HDIV_W-1:0]       d_ext;
  logic [HDIV_W-1:0]       d6;
  logic [HDIV_W-1:0]       num;
  logic [SATN_W-1:0]       sat_n;

  // elastic handshake: a stage loads when empty or when it drains
  assign s2_ready = !s2_valid_r || dn_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign up_ready = s1_ready;

  // stage 1: find the largest channel, red wins ties, then green
  always_comb begin
    info_nxt.red       = red;
    info_nxt.green     = green;
    info_nxt.blue      = blue;
    info_nxt.red_max   = (red >= green) && (red >= blue);
    info_nxt.green_max = !info_nxt.red_max && (green >= blue);
    if (info_nxt.red_max) begin
      info_nxt.hi = red;
    end else if (info_nxt.green_max) begin
      info_nxt.hi = green;
    end else begin
      info_nxt.hi = blue;
    end
    if ((red <= green) && (red <= blue)) begin
      info_nxt.lo = red;
    end else if (green <= blue) begin
      info_nxt.lo = green;
    end else begin
      info_nxt.lo = blue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      info_r <= info_nxt;
    end
  end

  // stage 2: spread d, the hue numerator and the saturation dividend
  assign d     = info_r.hi - info_r.lo;
  assign d_ext = HDIV_W'(d);
  assign d6    = (d_ext << 2) + (d_ext << 1);
  assign sat_n = {d, SAT_BITS'(0)} - SATN_W'(d);

  // hue numerator base*d + diff, always below 6*d
  always_comb begin
    if (info_r.red_max) begin
      if (info_r.green < info_r.blue) begin
        num = d6 - (HDIV_W'(info_r.blue) - HDIV_W'(info_r.green));
      end else begin
        num = HDIV_W'(info_r.green) - HDIV_W'(info_r.blue);
      end
    end else if (info_r.green_max) begin
      num = (d_ext << 1) + HDIV_W'(info_r.blue) - HDIV_W'(info_r.red);
    end else begin
      num = (d_ext << 2) + HDIV_W'(info_r.red) - HDIV_W'(info_r.green);
    end
  end

  // divider start values; the first remainders are already below the divisors
  always_comb begin
    setup_nxt.hue_rem  = num;
    setup_nxt.hue_div  = d6;
    setup_nxt.hue_quo  = '0;
    setup_nxt.sat_rem  = sat_n[SATN_W-1 -: SDIV_W];
    setup_nxt.sat_div  = info_r.hi;
    setup_nxt.sat_src  = DIV_BITS'(sat_n[SAT_BITS-1:0]) << (DIV_BITS - SAT_BITS);
    setup_nxt.sat_quo  = '0;
    setup_nxt.hue_zero = (d == '0);
    setup_nxt.sat_zero = (info_r.hi == '0);
    setup_nxt.value    = info_r.hi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      setup_r <= setup_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_data  = setup_r;

endmodule

`default_nettype wire

// ----- rtl/rhc_div_stage.sv -----
// one pipeline stage of the paired hue and saturation dividers,
// resolving STEPS_PER_STAGE quotient bits of each; depends on rhc_pkg
`default_nettype none

module rhc_div_stage (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      up_valid,
  output logic                     up_ready,
  input  wire rhc_pkg::div_state_t up_data,
  output logic                     dn_valid,
  input  wire                      dn_ready,
  output rhc_pkg::div_state_t      dn_data
);
  import rhc_pkg::*;

  logic       valid_r;
  div_state_t data_r;
  div_state_t data_nxt;

  assign up_ready = !valid_r || dn_ready;

  // restoring division steps for both quotients side by side
  always_comb begin
    hue_step_t hs;
    sat_step_t ss;
    data_nxt = up_data;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      hs = hue_div_step(data_nxt.hue_rem, data_nxt.hue_div);
      ss = sat_div_step(data_nxt.sat_rem, data_nxt.sat_div,
                        data_nxt.sat_src[DIV_BITS-1]);
      data_nxt.hue_rem = hs.rem;
      data_nxt.hue_quo = {data_nxt.hue_quo[DIV_BITS-2:0], hs.qbit};
      data_nxt.sat_rem = ss.rem;
      data_nxt.sat_quo = {data_nxt.sat_quo[DIV_BITS-2:0], ss.qbit};
      data_nxt.sat_src = {data_nxt.sat_src[DIV_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ----- rtl/rgb_to_hsv_convert.sv -----
// top level of the rgb to hsv converter: front end, divider pipeline and
// output register; depends on rhc_pkg, rhc_prep and rhc_div_stage
`default_nettype none

// Converts one 8-bit RGB pixel per clock into hue (fraction of a turn in
// units of 1/65536), saturation (65535 = 1.0, truncated) and value (largest
// channel). A new pixel is taken every cycle while the result side keeps up;
// the pixel passes through the two front-end stages, the divider pipeline that
// resolves 4 quotient bits of both hue and saturation per stage, and the output
// register. Every stage is elastic, so empty slots close up under out_stall and
// in_stall only rises when all stages hold a pixel and the output is stalled.
module rgb_to_hsv_convert (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [rhc_pkg::CHANNEL_BITS-1:0] in_red,
  input  wire  [rhc_pkg::CHANNEL_BITS-1:0] in_green,
  input  wire  [rhc_pkg::CHANNEL_BITS-1:0] in_blue,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [rhc_pkg::HUE_BITS-1:0]     out_hue,
  output logic [rhc_pkg::SAT_BITS-1:0]     out_saturation,
  output logic [rhc_pkg::CHANNEL_BITS-1:0] out_value
);
  import rhc_pkg::*;

  div_state_t              stage_data  [DIV_STAGES+1];
  logic [DIV_STAGES:0]     stage_valid;
  logic [DIV_STAGES:0]     stage_ready;
  logic                    in_ready;
  logic                    out_ready;
  logic                    out_valid_r;
  logic [HUE_BITS-1:0]     out_hue_r;
  logic [HUE_BITS-1:0]     out_hue_nxt;
  logic [SAT_BITS-1:0]     out_sat_r;
  logic [SAT_BITS-1:0]     out_sat_nxt;
  logic [CHANNEL_BITS-1:0] out_value_r;
  div_state_t              last;

  assign in_stall = !in_ready;

  // classification and divider setup
  rhc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .dn_valid (stage_valid[0]),
    .dn_ready (stage_ready[0]),
    .dn_data  (stage_data[0])
  );

  // divider pipeline
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    rhc_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stage_valid[i]),
      .up_ready (stage_ready[i]),
      .up_data  (stage_data[i]),
      .dn_valid (stage_valid[i+1]),
      .dn_ready (stage_ready[i+1]),
      .dn_data  (stage_data[i+1])
    );
  end

  // top quotient bits are the results; grey and black pixels force zero
  assign last        = stage_data[DIV_STAGES];
  assign out_hue_nxt = last.hue_zero ? '0 : last.hue_quo[DIV_BITS-1 -: HUE_BITS];
  assign out_sat_nxt = last.sat_zero ? '0 : last.sat_quo[DIV_BITS-1 -: SAT_BITS];

  // output register
  assign out_ready               = !out_valid_r || !out_stall;
  assign stage_ready[DIV_STAGES] = out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= stage_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && stage_valid[DIV_STAGES]) begin
      out_hue_r   <= out_hue_nxt;
      out_sat_r   <= out_sat_nxt;
      out_value_r <= last.value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = out_hue_r;
  assign out_saturation = out_sat_r;
  assign out_value      = out_value_r;

endmodule

`default_nettype wire

// ----- rtl/rhc_checker.sv -----
// port-level checks for the rgb to hsv converter and their bind
// depends on rhc_pkg and rgb_to_hsv_convert_defines.svh
`default_nettype none

`include "rgb_to_hsv_convert_defines.svh"

module rhc_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_stall,
  input wire [rhc_pkg::CHANNEL_BITS-1:0]  in_red,
  input wire [rhc_pkg::CHANNEL_BITS-1:0]  in_green,
  input wire [rhc_pkg::CHANNEL_BITS-1:0]  in_blue,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire [rhc_pkg::HUE_BITS-1:0]      out_hue,
  input wire [rhc_pkg::SAT_BITS-1:0]      out_saturation,
  input wire [rhc_pkg::CHANNEL_BITS-1:0]  out_value
);

  // a stalled output transaction keeps its payload
  `RHC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hue) && $stable(out_saturation) && $stable(out_value), "stalled output transaction changed")

  // input backpressure only when the whole pipe is full behind a stalled output
  `RHC_ASSERT_SAME(a_stall_full, in_stall, out_valid && out_stall, "input stalled without a stalled output")

  // a black pixel has neither saturation nor hue
  `RHC_ASSERT_SAME(a_black, out_valid && (out_value == '0), (out_saturation == '0) && (out_hue == '0), "black pixel with nonzero hue or saturation")

  // zero saturation means a grey pixel, which has zero hue
  `RHC_ASSERT_SAME(a_grey, out_valid && (out_saturation == '0), out_hue == '0, "grey pixel with nonzero hue")

endmodule

bind rgb_to_hsv_convert rhc_checker u_rhc_checker (.*);

`default_nettype wire
